// File: hdl/twepq_pkg.sv
`timescale 1ns / 1ps

package twepq_pkg;

   // default sizes of the queue
   localparam int DEF_QUEUE_DEPTH  = 64;
   localparam int DEF_MAX_BURST    = 16;
   localparam int DEF_HANDLE_WIDTH = 32;

   // fixed widths of the channel fields
   localparam int TYPE_W   = 2;
   localparam int PORT_HW  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 7;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_PUSH      = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_POP_UPTO  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_POP_EXACT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd3;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   // slot store access strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: hdl/twepq_if.sv
`timescale 1ns / 1ps

// request channel
interface twepq_req_if import twepq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    req_type;
   logic [PORT_HW-1:0]   item_handle;
   logic                 urgent;
   logic [COUNT_W-1:0]   count;

   modport source (output valid, req_type, item_handle, urgent, count, input ready);
   modport sink   (input valid, req_type, item_handle, urgent, count, output ready);
endinterface

// result channel
interface twepq_rsp_if import twepq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PORT_HW-1:0]   popped_handle;
   logic                 last;
   logic [LEVEL_W-1:0]   occupancy;
   logic [LEVEL_W-1:0]   urgent_count;

   modport source (output valid, status, popped_handle, last, occupancy, urgent_count,
                   input ready);
   modport sink   (input valid, status, popped_handle, last, occupancy, urgent_count,
                   output ready);
endinterface

// File: hdl/twepq_store.sv
`timescale 1ns / 1ps

module twepq_store import twepq_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int DW    = DEF_HANDLE_WIDTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  mem_ctl_type   mem_ctl,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] slot_store_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         slot_store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= slot_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/twepq_ctrl.sv
`timescale 1ns / 1ps

module twepq_ctrl import twepq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int MAX_BURST    = DEF_MAX_BURST,
   parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH,
   localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   twepq_req_if.sink               req_ch,
   twepq_rsp_if.source             rsp_ch,
   output mem_ctl_type             mem_ctl,
   output logic [AW-1:0]           wr_addr,
   output logic [HANDLE_WIDTH-1:0] wr_data,
   output logic [AW-1:0]           rd_addr,
   input  logic [HANDLE_WIDTH-1:0] rd_data
);

   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_LVL  = CW'(QUEUE_DEPTH);

   state_type                 state_ff, state_in;
   logic [TYPE_W-1:0]         type_ff, type_in;
   logic [HANDLE_WIDTH-1:0]   handle_ff, handle_in;
   logic                      urgent_ff, urgent_in;
   logic [COUNT_W-1:0]        want_ff, want_in;
   logic [COUNT_W-1:0]        remain_ff, remain_in;
   logic [AW-1:0]             pop_ptr_ff, pop_ptr_in;
   logic [AW-1:0]             far_ptr_ff, far_ptr_in;
   logic [CW-1:0]             held_ff, held_in;
   logic [CW-1:0]             tally_ff, tally_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [PORT_HW-1:0]        rsp_handle_ff, rsp_handle_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [LEVEL_W-1:0]        rsp_occ_ff, rsp_occ_in;
   logic [LEVEL_W-1:0]        rsp_urg_ff, rsp_urg_in;

   logic                      out_free;
   logic [AW-1:0]             pop_prev;
   logic [AW-1:0]             pop_next;
   logic [AW-1:0]             far_prev;
   logic [HANDLE_WIDTH+PORT_HW-1:0] in_ext;
   logic [HANDLE_WIDTH+PORT_HW-1:0] out_ext;
   logic [COUNT_W-1:0]        take;

   // ring neighbors of the two ends
   assign pop_prev = (pop_ptr_ff == '0) ? LAST_SLOT : pop_ptr_ff - AW'(1);
   assign pop_next = (pop_ptr_ff == LAST_SLOT) ? '0 : pop_ptr_ff + AW'(1);
   assign far_prev = (far_ptr_ff == '0) ? LAST_SLOT : far_ptr_ff - AW'(1);

   // handle width adaptation between port and store
   assign in_ext  = {{HANDLE_WIDTH{1'b0}}, req_ch.item_handle};
   assign out_ext = {{PORT_HW{1'b0}}, rd_data};

   // items a pop will take
   assign take = (CMPW'(held_ff) < CMPW'(want_ff)) ? COUNT_W'(held_ff) : want_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // state and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_ptr_ff   <= '0;
         far_ptr_ff   <= '0;
         held_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_ptr_ff   <= pop_ptr_in;
         far_ptr_ff   <= far_ptr_in;
         held_ff      <= held_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      handle_ff     <= handle_in;
      urgent_ff     <= urgent_in;
      want_ff       <= want_in;
      remain_ff     <= remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_urg_ff    <= rsp_urg_in;
   end

   // sequencer: one request at a time, one popped item per cycle while the result channel is free
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      handle_in     = handle_ff;
      urgent_in     = urgent_ff;
      want_in       = want_ff;
      remain_in     = remain_ff;
      pop_ptr_in    = pop_ptr_ff;
      far_ptr_in    = far_ptr_ff;
      held_in       = held_ff;
      tally_in      = tally_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_urg_in    = rsp_urg_ff;
      mem_ctl       = '0;
      wr_addr       = pop_ptr_ff;
      wr_data       = handle_ff;
      rd_addr       = pop_prev;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               type_in   = req_ch.req_type;
               handle_in = in_ext[HANDLE_WIDTH-1:0];
               urgent_in = req_ch.urgent;
               // clamp the burst size
               if (req_ch.count == '0) begin
                  want_in = COUNT_W'(1);
               end else if (int'(req_ch.count) > MAX_BURST) begin
                  want_in = COUNT_W'(MAX_BURST);
               end else begin
                  want_in = req_ch.count;
               end
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
               unique case (type_ff) inside
                  REQ_PUSH: begin
                     if (held_ff == FULL_LVL) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        held_in       = held_ff + CW'(1);
                        if (urgent_ff) begin
                           wr_addr    = pop_ptr_ff;
                           pop_ptr_in = pop_next;
                           if (tally_ff < FULL_LVL) begin
                              tally_in = tally_ff + CW'(1);
                           end
                        end else begin
                           wr_addr    = far_prev;
                           far_ptr_in = far_prev;
                        end
                     end
                  end
                  REQ_POP_UPTO, REQ_POP_EXACT: begin
                     if (held_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (type_ff == REQ_POP_EXACT &&
                                  CMPW'(held_ff) < CMPW'(want_ff)) begin
                        rsp_status_in = STAT_SHORT;
                     end else begin
                        // first read; the result goes out when data returns
                        rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
                        rsp_status_in = rsp_status_ff;
                        rsp_handle_in = rsp_handle_ff;
                        rsp_last_in   = rsp_last_ff;
                        mem_ctl.rd_en = 1'b1;
                        pop_ptr_in    = pop_prev;
                        held_in       = held_ff - CW'(1);
                        if (tally_ff != '0) begin
                           tally_in = tally_ff - CW'(1);
                        end
                        remain_in = take - COUNT_W'(1);
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_occ_in = LEVEL_W'(held_in);
                  rsp_urg_in = LEVEL_W'(tally_in);
               end
            end
         end

         ST_READ: begin
            if (out_free) begin
               // emit the fetched item with the levels after its removal
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_handle_in = out_ext[PORT_HW-1:0];
               rsp_last_in   = (remain_ff == '0);
               rsp_occ_in    = LEVEL_W'(held_ff);
               rsp_urg_in    = LEVEL_W'(tally_ff);
               if (remain_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  pop_ptr_in    = pop_prev;
                  held_in       = held_ff - CW'(1);
                  if (tally_ff != '0) begin
                     tally_in = tally_ff - CW'(1);
                  end
                  remain_in = remain_ff - COUNT_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result channel drive
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.popped_handle = rsp_handle_ff;
   assign rsp_ch.last          = rsp_last_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;
   assign rsp_ch.urgent_count  = rsp_urg_ff;

endmodule

// File: hdl/two_ended_priority_work_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of work item handles held in a single-port-write,
// single-port-read slot memory with a registered read port.
// Request channel (req_ch): push, pop up to count, pop exactly count. An urgent
// push goes in at the pop end, a normal push at the far end; pops take from
// the pop end. Result channel (rsp_ch): one item per push, refusal or ignored
// request, one item per popped handle otherwise, last marks the final one;
// each result carries occupancy and urgent count after it.
// Timing: an item is taken in the idle state only. A push, refusal or ignored
// request is carried out in the exec state, which registers its result; the next
// request can be taken in the same cycle that the result shows. A pop issues
// its first read in the exec state and emits the fetched handle from the read
// state, then one handle per cycle, gated by the read port and by receiver stalls.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and held until that register frees up.
// Reset (synchronous, active high) empties the queue and clears the urgent
// count; the slot memory itself is not cleared and needs no clearing pass.
module two_ended_priority_work_queue import twepq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int MAX_BURST    = DEF_MAX_BURST,
   parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   twepq_req_if.sink   req_ch,
   twepq_rsp_if.source rsp_ch
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   mem_ctl_type             mem_ctl;
   logic [AW-1:0]           wr_addr;
   logic [HANDLE_WIDTH-1:0] wr_data;
   logic [AW-1:0]           rd_addr;
   logic [HANDLE_WIDTH-1:0] rd_data;

   // request sequencer and result register
   twepq_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_BURST    (MAX_BURST),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot memory
   twepq_store #(
      .DEPTH (QUEUE_DEPTH),
      .DW    (HANDLE_WIDTH)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
